// ----- rtl/smx_pkg.sv -----
// Types and codes shared by the stack machine executor.
// No dependencies; imported by the top level and the stack RAM.
package smx_pkg;

	localparam int unsigned WORD_W = 32;

	// opcodes
	localparam logic [3:0] OP_PSH  = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_POP  = 4'd2;
	localparam logic [3:0] OP_SET  = 4'd3;
	localparam logic [3:0] OP_ADDI = 4'd4;
	localparam logic [3:0] OP_MULT = 4'd5;
	localparam logic [3:0] OP_SUB  = 4'd6;
	localparam logic [3:0] OP_DIV  = 4'd7;
	localparam logic [3:0] OP_LOG  = 4'd8;
	localparam logic [3:0] OP_LTS  = 4'd9;
	localparam logic [3:0] OP_HLT  = 4'd10;

	// register indexes
	localparam logic [3:0] REG_IP = 4'd7;
	localparam logic [3:0] REG_SP = 4'd8;

	// emit kinds
	localparam logic [1:0] EMIT_NONE = 2'd0;
	localparam logic [1:0] EMIT_POP  = 2'd1;
	localparam logic [1:0] EMIT_LOG  = 2'd2;

	// fault codes
	localparam logic [2:0] FLT_OK     = 3'd0;
	localparam logic [2:0] FLT_UNDER  = 3'd1;
	localparam logic [2:0] FLT_OVER   = 3'd2;
	localparam logic [2:0] FLT_DIVZ   = 3'd3;
	localparam logic [2:0] FLT_BADREG = 3'd4;

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_READ_T = 8'b0000_0100,
		ST_READ_S = 8'b0000_1000,
		ST_EXEC   = 8'b0001_0000,
		ST_DIV    = 8'b0010_0000,
		ST_DIVEND = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	typedef logic [WORD_W-1:0] word_t;

endpackage

// ----- rtl/smx_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on smx_pkg only for the word type convention; width and depth are parameters.
module smx_ram
	import smx_pkg::*;
#(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/stack_machine_executor_top.sv -----
// Stack machine executor: one decoded instruction per input word, one result word out.
// Depends on smx_pkg and smx_ram (stack store).
//
// channel  | dir | handshake                  | contents
// s_axis   | in  | s_axis_tvalid/tready       | tuser: req_type; tdata: reg_index, immediate
// m_axis   | out | m_axis_tvalid/tready       | tuser: emit_kind; tdata: value, address, flags
//
// After reset the stack store is swept to zero with ready held low.
// A word passes through accept, two stack RAM reads (top, second), execute and result load.
// DIV adds the one-bit-per-cycle restoring divider (ST_DIV) and its write-back (ST_DIVEND).
// A new word is taken while the previous result still waits in the output register;
// the result load waits for that register to drain.
module stack_machine_executor_top
	import smx_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [3:0] reg_index, [35:4] immediate, [39:36] zero
	input  logic [3:0]  s_axis_tuser,  // [3:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // [31:0] emit_value, [63:32] next_address,
	                                   // [64] halted, [67:65] fault_code, [71:68] zero
	output logic [1:0]  m_axis_tuser   // [1:0] emit_kind
);

	localparam int unsigned AW  = $clog2(STACK_DEPTH);
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
	localparam logic [SPW-1:0] SP_ONE   = SPW'(1);
	localparam logic [SPW-1:0] SP_TWO   = SPW'(2);
	localparam logic [SPW-1:0] SP_DEPTH = SPW'(STACK_DEPTH);
	localparam word_t          W_DEPTH  = WORD_W'(STACK_DEPTH);
	localparam logic [AW-1:0]  CLR_LAST = AW'(STACK_DEPTH - 1);

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [3:0]        op_q;
	logic [3:0]        r_q;
	word_t             imm_q;
	word_t             t_q;
	word_t             gpr_q [7];
	word_t             ip_q;
	logic [SPW-1:0]    sp_q;
	logic              halt_q;

	// divider
	word_t             dq_q;
	word_t             drem_q;
	word_t             dden_q;
	logic [4:0]        dcnt_q;
	logic              dneg_q;

	// result and output registers
	logic [1:0]        res_kind_q;
	word_t             res_value_q;
	logic [2:0]        res_fault_q;
	logic              out_valid_q;
	logic [1:0]        out_kind_q;
	word_t             out_value_q;
	word_t             out_addr_q;
	logic              out_halt_q;
	logic [2:0]        out_fault_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	word_t             mem_wdata;
	logic [AW-1:0]     mem_raddr;
	word_t             mem_rdata;

	logic [SPW-1:0]    sp_m1;
	logic [SPW-1:0]    sp_m2;
	logic [SPW-1:0]    sp_p1;
	word_t             s_val;
	word_t             gpr_rd;
	word_t             old_val;
	word_t             new_val;
	word_t             alu_res;
	logic [63:0]       prod;

	// execute-step decisions
	logic [2:0]        x_fault;
	logic [1:0]        x_kind;
	word_t             x_value;
	word_t             x_ip;
	logic              x_sp_we;
	logic [SPW-1:0]    x_sp;
	logic              x_gpr_we;
	word_t             x_gpr_val;
	logic              x_mem_we;
	logic [AW-1:0]     x_mem_addr;
	word_t             x_mem_data;
	logic              x_halt;
	logic              x_div;

	// divider step
	logic [32:0]       d_cand;
	logic [33:0]       d_diff;
	logic              d_ge;
	word_t             d_quot;

	logic              in_fire;
	logic              out_free;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign sp_m1 = sp_q - SP_ONE;
	assign sp_m2 = sp_q - SP_TWO;
	assign sp_p1 = sp_q + SP_ONE;
	assign s_val = mem_rdata;

	always_comb begin
		gpr_rd = '0;
		for (int i = 0; i < 7; i++) begin
			if (r_q == 4'(i)) begin
				gpr_rd = gpr_q[i];
			end
		end
	end

	always_comb begin
		if (r_q == REG_SP) begin
			old_val = WORD_W'(sp_q);
		end else if (r_q == REG_IP) begin
			old_val = ip_q + 32'd3;
		end else begin
			old_val = gpr_rd;
		end
		new_val = (op_q == OP_SET) ? imm_q : old_val + imm_q;
	end

	// shared arithmetic unit: s is the second entry, t the top
	assign prod = 64'(s_val) * 64'(t_q);
	always_comb begin
		case (op_q)
			OP_ADD:  alu_res = s_val + t_q;
			OP_MULT: alu_res = prod[31:0];
			OP_SUB:  alu_res = t_q - s_val;
			default: alu_res = '0;
		endcase
	end

	always_comb begin
		x_fault    = FLT_OK;
		x_kind     = EMIT_NONE;
		x_value    = '0;
		x_ip       = ip_q;
		x_sp_we    = 1'b0;
		x_sp       = sp_q;
		x_gpr_we   = 1'b0;
		x_gpr_val  = '0;
		x_mem_we   = 1'b0;
		x_mem_addr = sp_m2[AW-1:0];
		x_mem_data = alu_res;
		x_halt     = 1'b0;
		x_div      = 1'b0;
		if (!halt_q) begin
			case (op_q)
				OP_PSH: begin
					if (sp_q == SP_DEPTH) begin
						x_fault = FLT_OVER;
					end else begin
						x_mem_we   = 1'b1;
						x_mem_addr = sp_q[AW-1:0];
						x_mem_data = imm_q;
						x_sp_we    = 1'b1;
						x_sp       = sp_p1;
						x_ip       = ip_q + 32'd2;
					end
				end
				OP_POP: begin
					if (sp_q == '0) begin
						x_fault = FLT_UNDER;
					end else begin
						x_kind  = EMIT_POP;
						x_value = t_q;
						x_sp_we = 1'b1;
						x_sp    = sp_m1;
						x_ip    = ip_q + 32'd1;
					end
				end
				OP_ADD, OP_MULT, OP_SUB, OP_DIV: begin
					if (sp_q < SP_TWO) begin
						x_fault = FLT_UNDER;
					end else if (op_q == OP_DIV && s_val == '0) begin
						x_fault = FLT_DIVZ;
					end else if (op_q == OP_DIV) begin
						x_div = 1'b1;
					end else begin
						x_mem_we = 1'b1;
						x_sp_we  = 1'b1;
						x_sp     = sp_m1;
						x_ip     = ip_q + 32'd1;
					end
				end
				OP_SET, OP_ADDI: begin
					if (r_q > REG_SP) begin
						x_fault = FLT_BADREG;
					end else if (r_q == REG_SP) begin
						if (new_val > W_DEPTH) begin
							x_fault = FLT_BADREG;
						end else begin
							x_sp_we = 1'b1;
							x_sp    = new_val[SPW-1:0];
							x_ip    = ip_q + 32'd3;
						end
					end else if (r_q == REG_IP) begin
						x_ip = new_val;
					end else begin
						x_gpr_we  = 1'b1;
						x_gpr_val = new_val;
						x_ip      = ip_q + 32'd3;
					end
				end
				OP_LOG: begin
					x_kind  = EMIT_LOG;
					x_value = gpr_q[0];
					x_ip    = ip_q + 32'd1;
				end
				OP_LTS: begin
					if (r_q > REG_SP) begin
						x_fault = FLT_BADREG;
					end else if (sp_q == '0) begin
						x_fault = FLT_UNDER;
					end else if (r_q == REG_SP) begin
						// written value replaces the pop
						if (t_q > W_DEPTH) begin
							x_fault = FLT_BADREG;
						end else begin
							x_sp_we = 1'b1;
							x_sp    = t_q[SPW-1:0];
							x_ip    = ip_q + 32'd2;
						end
					end else begin
						x_sp_we = 1'b1;
						x_sp    = sp_m1;
						if (r_q == REG_IP) begin
							x_ip = t_q;
						end else begin
							x_gpr_we  = 1'b1;
							x_gpr_val = t_q;
							x_ip      = ip_q + 32'd2;
						end
					end
				end
				OP_HLT: begin
					x_halt = 1'b1;
					x_ip   = ip_q + 32'd1;
				end
				default: begin
					x_ip = ip_q + 32'd1;
				end
			endcase
		end
	end

	// restoring divider, one quotient bit a cycle
	assign d_cand = {drem_q, dq_q[31]};
	assign d_diff = {1'b0, d_cand} - {2'b00, dden_q};
	assign d_ge   = !d_diff[33];
	assign d_quot = dneg_q ? (32'd0 - dq_q) : dq_q;

	always_comb begin
		case (state_q)
			ST_READ_T: mem_raddr = sp_m1[AW-1:0];
			default:   mem_raddr = sp_m2[AW-1:0];
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = sp_m2[AW-1:0];
		mem_wdata = d_quot;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_EXEC: begin
				mem_we    = x_mem_we;
				mem_waddr = x_mem_addr;
				mem_wdata = x_mem_data;
			end
			ST_DIVEND: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	smx_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ip_q        <= '0;
			sp_q        <= '0;
			halt_q      <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 7; i++) begin
				gpr_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_READ_T;
					end
				end
				ST_READ_T: begin
					state_q <= ST_READ_S;
				end
				ST_READ_S: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (x_div) begin
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						ip_q    <= x_ip;
						halt_q  <= halt_q | x_halt;
						if (x_sp_we) begin
							sp_q <= x_sp;
						end
						if (x_gpr_we) begin
							for (int i = 0; i < 7; i++) begin
								if (r_q == 4'(i)) begin
									gpr_q[i] <= x_gpr_val;
								end
							end
						end
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) begin
						state_q <= ST_DIVEND;
					end
				end
				ST_DIVEND: begin
					sp_q    <= sp_m1;
					ip_q    <= ip_q + 32'd1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= s_axis_tuser;
			r_q   <= s_axis_tdata[3:0];
			imm_q <= s_axis_tdata[35:4];
		end
		if (state_q == ST_READ_S) begin
			t_q <= mem_rdata;
		end
		if (state_q == ST_EXEC) begin
			res_kind_q  <= x_kind;
			res_value_q <= x_value;
			res_fault_q <= x_fault;
			// load magnitudes: numerator is the top, divisor the second entry
			dq_q   <= t_q[31] ? (32'd0 - t_q) : t_q;
			dden_q <= s_val[31] ? (32'd0 - s_val) : s_val;
			drem_q <= '0;
			dneg_q <= t_q[31] ^ s_val[31];
		end
		if (state_q == ST_DIV) begin
			drem_q <= d_ge ? d_diff[31:0] : d_cand[31:0];
			dq_q   <= {dq_q[30:0], d_ge};
		end
		if (state_q == ST_DONE && out_free) begin
			out_kind_q  <= res_kind_q;
			out_value_q <= res_value_q;
			out_addr_q  <= ip_q;
			out_halt_q  <= halt_q;
			out_fault_q <= res_fault_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {4'd0, out_fault_q, out_halt_q, out_addr_q, out_value_q};

	a_sp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_DEPTH)
		else $error("stack pointer beyond stack depth");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	a_mem_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_EXEC || state_q == ST_DIVEND))
		else $error("stack write outside clear, execute or divide end");

	a_fault_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[67:65] != FLT_OK) |-> m_axis_tuser == EMIT_NONE)
		else $error("faulting word carries an emitted value");

	a_accept_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_READ_T)
		else $error("accepted word did not start the stack read");

endmodule

// ----- test/tb_stack_machine_executor_top.sv -----
// Self-checking testbench for the stack machine executor top level.
// Drives instruction words, predicts each result word in place (a directed row may give it) and compares whole words.
// Depends on smx_pkg and the RTL of stack_machine_executor_top.
`timescale 1ns / 100ps

module tb_stack_machine_executor_top;
	import smx_pkg::*;

	localparam int unsigned DEPTH       = 256;
	localparam word_t       STACK_LIMIT = 32'd256;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          RANDOM_WORDS = 800;

	// opcodes with no operation, and register selects
	localparam logic [3:0] OP_SPARE_LO = 4'd11;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;
	localparam logic [3:0] REG_A       = 4'd0;
	localparam logic [3:0] REG_BAD_LO  = 4'd9;
	localparam logic [3:0] REG_BAD_HI  = 4'd15;

	typedef struct packed {
		logic [1:0] kind;
		word_t      value;
		word_t      addr;
		logic       halted;
		logic [2:0] fault;
	} result_t;

	typedef struct {
		logic [3:0] op;
		logic [3:0] sel;
		word_t      imm;
		bit         typed;
		result_t    want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [3:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	// machine state as the predictor sees it
	word_t      gpr_q [7];
	word_t      ip_q;
	logic [8:0] sp_q;
	word_t      stack_mem [DEPTH];
	bit         halt_q;
	word_t      next_ip;

	result_t pending_results [$];
	row_t    directed_rows [$];

	int  errors;
	int  words_sent;
	int  results_seen;
	int  faults_seen;
	int  emits_seen;
	int  cycle_count;
	bit  quiet;
	bit  hold_request;

	stack_machine_executor_top #(
		.STACK_DEPTH(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [2:0] write_target(logic [3:0] sel, word_t val);
		if (sel == REG_SP) begin
			if (val > STACK_LIMIT)
				return FLT_BADREG;
			sp_q = val[8:0];
		end else if (sel == REG_IP) begin
			next_ip = val;
		end else begin
			gpr_q[sel[2:0]] = val;
		end
		return FLT_OK;
	endfunction

	function automatic result_t execute_word(logic [3:0] op, logic [3:0] sel, word_t imm);
		result_t res;
		word_t   top;
		word_t   second;
		word_t   val;
		word_t   mag_t;
		word_t   mag_s;
		word_t   quo;
		res     = '0;
		next_ip = ip_q;
		if (!halt_q) begin
			case (op)
				OP_PSH: begin
					if (sp_q >= STACK_LIMIT) begin
						res.fault = FLT_OVER;
					end else begin
						stack_mem[sp_q[7:0]] = imm;
						sp_q    = sp_q + 9'd1;
						next_ip = ip_q + 2;
					end
				end
				OP_POP: begin
					if (sp_q == 0) begin
						res.fault = FLT_UNDER;
					end else begin
						res.kind  = EMIT_POP;
						res.value = stack_mem[sp_q[7:0] - 8'd1];
						sp_q    = sp_q - 9'd1;
						next_ip = ip_q + 1;
					end
				end
				OP_ADD, OP_MULT, OP_SUB, OP_DIV: begin
					if (sp_q < 2) begin
						res.fault = FLT_UNDER;
					end else begin
						top    = stack_mem[sp_q[7:0] - 8'd1];
						second = stack_mem[sp_q[7:0] - 8'd2];
						if (op == OP_DIV && second == 0) begin
							res.fault = FLT_DIVZ;
						end else begin
							case (op)
								OP_ADD:  val = second + top;
								OP_MULT: val = second * top;
								OP_SUB:  val = top - second;
								default: begin
									// divide on magnitudes so that the most negative word wraps
									mag_t = top[31] ? -top : top;
									mag_s = second[31] ? -second : second;
									quo   = mag_t / mag_s;
									val   = (top[31] ^ second[31]) ? -quo : quo;
								end
							endcase
							stack_mem[sp_q[7:0] - 8'd2] = val;
							sp_q    = sp_q - 9'd1;
							next_ip = ip_q + 1;
						end
					end
				end
				OP_SET, OP_ADDI: begin
					if (sel > REG_SP) begin
						res.fault = FLT_BADREG;
					end else begin
						next_ip = ip_q + 3;
						if (sel == REG_SP)
							val = {23'b0, sp_q};
						else if (sel == REG_IP)
							val = next_ip;
						else
							val = gpr_q[sel[2:0]];
						val = (op == OP_SET) ? imm : val + imm;
						res.fault = write_target(sel, val);
						if (res.fault != FLT_OK)
							next_ip = ip_q;
					end
				end
				OP_LOG: begin
					res.kind  = EMIT_LOG;
					res.value = gpr_q[0];
					next_ip   = ip_q + 1;
				end
				OP_LTS: begin
					if (sel > REG_SP) begin
						res.fault = FLT_BADREG;
					end else if (sp_q == 0) begin
						res.fault = FLT_UNDER;
					end else begin
						top     = stack_mem[sp_q[7:0] - 8'd1];
						next_ip = ip_q + 2;
						sp_q    = sp_q - 9'd1;
						res.fault = write_target(sel, top);
						if (res.fault != FLT_OK) begin
							sp_q    = sp_q + 9'd1;
							next_ip = ip_q;
						end
					end
				end
				OP_HLT: begin
					halt_q  = 1'b1;
					next_ip = ip_q + 1;
				end
				default: next_ip = ip_q + 1;
			endcase
			ip_q = next_ip;
		end
		res.addr   = ip_q;
		res.halted = halt_q;
		return res;
	endfunction

	function automatic row_t mk_row(logic [3:0] op, logic [3:0] sel, word_t imm, bit typed,
			result_t want);
		row_t r;
		r.op    = op;
		r.sel   = sel;
		r.imm   = imm;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	function automatic void add_row(row_t r);
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	// Call at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(logic [3:0] op, logic [3:0] sel, word_t imm, bit typed,
			result_t want);
		result_t pred;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, imm, sel};
		do @(posedge clk); while (!s_axis_tready);
		pred = execute_word(op, sel, imm);
		pending_results.insert(pending_results.size(), typed ? want : pred);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic random_word(output logic [3:0] op, output logic [3:0] sel,
			output word_t imm);
		int w;
		w = $urandom_range(0, 99);
		if (w < 26)      op = OP_PSH;
		else if (w < 38) op = OP_POP;
		else if (w < 46) op = OP_ADD;
		else if (w < 52) op = OP_MULT;
		else if (w < 58) op = OP_SUB;
		else if (w < 66) op = OP_DIV;
		else if (w < 73) op = OP_SET;
		else if (w < 80) op = OP_ADDI;
		else if (w < 86) op = OP_LOG;
		else if (w < 93) op = OP_LTS;
		else             op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		if ($urandom_range(0, 4) == 0)
			sel = 4'($urandom_range(REG_BAD_LO, REG_BAD_HI));
		else
			sel = 4'($urandom_range(REG_A, REG_SP));
		case ($urandom_range(0, 9))
			0:       imm = 32'h0000_0000;
			1:       imm = 32'h7FFF_FFFF;
			2:       imm = 32'h8000_0000;
			3:       imm = 32'hFFFF_FFFF;
			4, 5, 6: imm = word_t'($urandom_range(0, 20)) - 32'd10;
			default: imm = $urandom();
		endcase
		// keep stack pointer writes near the legal range so both limits are hit
		if (sel == REG_SP && op == OP_SET)
			imm = word_t'($urandom_range(0, 260));
		else if (sel == REG_SP && op == OP_ADDI)
			imm = word_t'($urandom_range(0, 8)) - 32'd4;
	endtask

	task automatic check_result(result_t got);
		result_t want;
		results_seen++;
		if (got.fault != FLT_OK)
			faults_seen++;
		if (got.kind != EMIT_NONE)
			emits_seen++;
		if (pending_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result word: kind %0d value %h addr %h halted %0d fault %0d",
					got.kind, got.value, got.addr, got.halted, got.fault);
		end else begin
			want = pending_results.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("result %0d mismatch: kind %0d/%0d value %h/%h addr %h/%h halted %0d/%0d fault %0d/%0d (exp/got)",
						results_seen, want.kind, got.kind, want.value, got.value,
						want.addr, got.addr, want.halted, got.halted, want.fault, got.fault);
			end
		end
	endtask

	// receiver: random stalls, long hold on request, check every taken word
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (quiet) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_result({m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
					m_axis_tdata[64], m_axis_tdata[67:65]});
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [3:0] op;
		logic [3:0] sel;
		word_t      imm;
		errors = 0; words_sent = 0; results_seen = 0; faults_seen = 0; emits_seen = 0;
		quiet = 1'b0;
		hold_request = 1'b0;
		foreach (gpr_q[i]) gpr_q[i] = '0;
		foreach (stack_mem[i]) stack_mem[i] = '0;
		ip_q   = '0;
		sp_q   = '0;
		halt_q = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_PSH;

		add_row(mk_row(OP_POP, REG_A, 0, 1'b1,
			result_t'{EMIT_NONE, 0, 0, 1'b0, FLT_UNDER}));
		add_row(mk_row(OP_ADD, REG_A, 0, 1'b1,
			result_t'{EMIT_NONE, 0, 0, 1'b0, FLT_UNDER}));
		add_row(mk_row(OP_LTS, REG_A, 0, 1'b1,
			result_t'{EMIT_NONE, 0, 0, 1'b0, FLT_UNDER}));
		add_row(mk_row(OP_LOG, REG_A, 0, 1'b1,
			result_t'{EMIT_LOG, 0, 1, 1'b0, FLT_OK}));
		add_row(mk_row(OP_SET, REG_BAD_LO, 5, 1'b1,
			result_t'{EMIT_NONE, 0, 1, 1'b0, FLT_BADREG}));
		add_row(mk_row(OP_LTS, REG_BAD_HI, 0, 1'b1,
			result_t'{EMIT_NONE, 0, 1, 1'b0, FLT_BADREG}));
		add_row(mk_row(OP_SET, REG_A, 32'h8000_0000, 1'b0, '0));
		add_row(mk_row(OP_LOG, REG_A, 0, 1'b1,
			result_t'{EMIT_LOG, 32'h8000_0000, 5, 1'b0, FLT_OK}));
		add_row(mk_row(OP_ADDI, REG_A, 32'hFFFF_FFFF, 1'b0, '0));
		add_row(mk_row(OP_PSH, REG_A, 32'h7FFF_FFFF, 1'b0, '0));
		add_row(mk_row(OP_PSH, REG_A, 32'h7FFF_FFFF, 1'b0, '0));
		add_row(mk_row(OP_ADD, REG_A, 0, 1'b0, '0));
		add_row(mk_row(OP_PSH, REG_A, 0, 1'b0, '0));
		add_row(mk_row(OP_PSH, REG_A, 5, 1'b0, '0));
		add_row(mk_row(OP_DIV, REG_A, 0, 1'b0, '0));
		add_row(mk_row(OP_POP, REG_A, 0, 1'b0, '0));
		add_row(mk_row(OP_PSH, REG_A, 32'hFFFF_FFFF, 1'b0, '0));
		add_row(mk_row(OP_PSH, REG_A, 32'h8000_0000, 1'b0, '0));
		add_row(mk_row(OP_DIV, REG_A, 0, 1'b0, '0));
		add_row(mk_row(OP_PSH, REG_A, 3, 1'b0, '0));
		add_row(mk_row(OP_MULT, REG_A, 0, 1'b0, '0));
		add_row(mk_row(OP_SUB, REG_A, 0, 1'b0, '0));
		add_row(mk_row(OP_SET, REG_SP, 257, 1'b0, '0));
		add_row(mk_row(OP_SET, REG_SP, 256, 1'b0, '0));
		add_row(mk_row(OP_PSH, REG_A, 1, 1'b0, '0));
		add_row(mk_row(OP_LTS, REG_SP, 0, 1'b0, '0));
		add_row(mk_row(OP_ADDI, REG_SP, 32'hFFFF_FFFF, 1'b0, '0));
		add_row(mk_row(OP_ADDI, REG_IP, 16, 1'b0, '0));
		add_row(mk_row(OP_SET, REG_IP, 32'hFFFF_FFFF, 1'b0, '0));
		add_row(mk_row(OP_SPARE_HI, REG_BAD_HI, 32'hFFFF_FFFF, 1'b0, '0));
		add_row(mk_row(OP_PSH, REG_A, 32'h1234_5678, 1'b0, '0));
		add_row(mk_row(OP_LTS, REG_IP, 0, 1'b0, '0));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_word(directed_rows[i].op, directed_rows[i].sel, directed_rows[i].imm,
				directed_rows[i].typed, directed_rows[i].want);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 200)
				hold_request = 1'b1;
			if (n == 400) begin
				// drain every outstanding result before going on
				s_axis_tvalid <= 1'b0;
				wait (pending_results.size() == 0);
				@(negedge clk);
			end
			if (n == RANDOM_WORDS - 150)
				quiet = 1'b1;
			random_word(op, sel, imm);
			send_word(op, sel, imm, 1'b0, '0);
		end

		// halt last: nothing after it may change state
		send_word(OP_HLT, REG_A, 0, 1'b0, '0);
		send_word(OP_PSH, REG_A, 32'hA5A5_A5A5, 1'b0, '0);
		send_word(OP_LOG, REG_A, 0, 1'b0, '0);
		send_word(OP_POP, REG_A, 0, 1'b0, '0);
		s_axis_tvalid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (60) @(posedge clk);
		if (pending_results.size() != 0)
			errors++;

		$display("%0d instruction words driven, %0d result words checked in %0d cycles",
			words_sent, results_seen, cycle_count);
		$display("%0d faulting words and %0d emitted values seen, %0d errors",
			faults_seen, emits_seen, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
